@@ rtl/dhdc_pkg.sv @@
package dhdc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_HEATING  = 2'd1,
    MODE_COOLDOWN = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_START      = 4'd1,
    EV_CUTOFF     = 4'd2,
    EV_HUMID_EXIT = 4'd3,
    EV_COOLDOWN   = 4'd4,
    EV_REHEAT     = 4'd5,
    EV_DONE       = 4'd6,
    EV_FAULT      = 4'd7,
    EV_TOO_COLD   = 4'd8
  } event_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_HUM_ENTER  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HUM_LEAVE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_T   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CUTOFF_T   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MINIMUM_T  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ON_PHASE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OFF_PHASE  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_POLL  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [9:0]         RST_HUM_ENTER = 10'd700;
  localparam logic [9:0]         RST_HUM_LEAVE = 10'd550;
  localparam logic signed [11:0] RST_TARGET_T  = 12'sd400;
  localparam logic signed [11:0] RST_CUTOFF_T  = 12'sd450;
  localparam logic signed [11:0] RST_MINIMUM_T = 12'sd100;
  localparam logic [23:0]        RST_ON_PHASE  = 24'd60000;
  localparam logic [23:0]        RST_OFF_PHASE = 24'd120000;
  localparam logic [23:0]        RST_IDLE_POLL = 24'd30000;

  typedef struct packed {
    logic [9:0]         hum_enter;
    logic [9:0]         hum_leave;
    logic signed [11:0] target_t;
    logic signed [11:0] cutoff_t;
    logic signed [11:0] minimum_t;
    logic [23:0]        on_phase;
    logic [23:0]        off_phase;
    logic [23:0]        idle_poll;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        heater;
    logic [31:0] last_sample;
    logic [31:0] phase_start;
  } ctl_state_t;

endpackage

@@ rtl/defog_heater_duty_controller.sv @@
// An accepted word waits in the input register, then moves to the result register.
// Throughput: one word per cycle while out_ready drains results; the two registers
// are separate, so one further word is taken while a result waits for out_ready.
// Reset (rst_n low, synchronous): idle mode, heater off, both time stamps
// zero, configuration registers at their defaults, both stages empty.
module defog_heater_duty_controller
  import dhdc_pkg::*;
#(
  parameter int unsigned ACTIVE_POLL_MS = 10000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_now_ms,
  input  logic [9:0]          in_humidity,
  input  logic signed [11:0]  in_temperature,
  input  logic                in_sensor_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_heater_on,
  output logic [1:0]          out_mode,
  output logic                out_sampled,
  output logic [3:0]          out_event_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t               cfg_r;
  ctl_state_t         st_r;
  ctl_state_t         st_nxt;
  logic               in_vld_r;
  logic [31:0]        now_r;
  logic [9:0]         hum_r;
  logic signed [11:0] temp_r;
  logic               ok_r;
  logic               out_vld_r;
  logic               heater_r;
  mode_t              mode_r;
  logic               sampled_r;
  event_t             event_r;
  logic               step_sampled;
  event_t             step_event;
  logic               adv;

  // The held word moves on when the result register is free or being drained.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hum_enter <= RST_HUM_ENTER;
      cfg_r.hum_leave <= RST_HUM_LEAVE;
      cfg_r.target_t  <= RST_TARGET_T;
      cfg_r.cutoff_t  <= RST_CUTOFF_T;
      cfg_r.minimum_t <= RST_MINIMUM_T;
      cfg_r.on_phase  <= RST_ON_PHASE;
      cfg_r.off_phase <= RST_OFF_PHASE;
      cfg_r.idle_poll <= RST_IDLE_POLL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HUM_ENTER: cfg_r.hum_enter <= cfg_data[9:0];
        CFG_HUM_LEAVE: cfg_r.hum_leave <= cfg_data[9:0];
        CFG_TARGET_T:  cfg_r.target_t  <= cfg_data[11:0];
        CFG_CUTOFF_T:  cfg_r.cutoff_t  <= cfg_data[11:0];
        CFG_MINIMUM_T: cfg_r.minimum_t <= cfg_data[11:0];
        CFG_ON_PHASE:  cfg_r.on_phase  <= cfg_data;
        CFG_OFF_PHASE: cfg_r.off_phase <= cfg_data;
        CFG_IDLE_POLL: cfg_r.idle_poll <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= in_now_ms;
      hum_r  <= in_humidity;
      temp_r <= in_temperature;
      ok_r   <= in_sensor_ok;
    end
  end

  dhdc_step #(
    .ACTIVE_POLL_MS(ACTIVE_POLL_MS)
  ) u_step (
    .cfg        (cfg_r),
    .cur        (st_r),
    .now_ms     (now_r),
    .humidity   (hum_r),
    .temperature(temp_r),
    .sensor_ok  (ok_r),
    .nxt        (st_nxt),
    .sampled    (step_sampled),
    .event_res  (step_event)
  );

  // Controller state is committed only when the word reaches the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= MODE_IDLE;
      st_r.heater      <= 1'b0;
      st_r.last_sample <= 32'd0;
      st_r.phase_start <= 32'd0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heater_r  <= st_nxt.heater;
      mode_r    <= st_nxt.mode;
      sampled_r <= step_sampled;
      event_r   <= step_event;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_heater_on = heater_r;
  assign out_mode      = mode_r;
  assign out_sampled   = sampled_r;
  assign out_event_res = event_r;

endmodule

@@ rtl/dhdc_step.sv @@
module dhdc_step
  import dhdc_pkg::*;
#(
  parameter int unsigned ACTIVE_POLL_MS = 10000
) (
  input  cfg_t               cfg,
  input  ctl_state_t         cur,
  input  logic [31:0]        now_ms,
  input  logic [9:0]         humidity,
  input  logic signed [11:0] temperature,
  input  logic               sensor_ok,
  output ctl_state_t         nxt,
  output logic               sampled,
  output event_t             event_res
);

  localparam logic [31:0] ActivePoll = 32'(ACTIVE_POLL_MS);

  logic [31:0] interval;
  logic [31:0] elapsed;
  logic [31:0] in_phase;
  logic        due;

  // Both differences wrap modulo 2^32, matching the free-running clock.
  assign interval = (cur.mode == MODE_IDLE) ? {8'd0, cfg.idle_poll} : ActivePoll;
  assign elapsed  = now_ms - cur.last_sample;
  assign in_phase = now_ms - cur.phase_start;
  assign due      = (elapsed >= interval);

  always_comb begin
    nxt       = cur;
    sampled   = 1'b0;
    event_res = EV_NONE;
    if (due) begin
      nxt.last_sample = now_ms;
      sampled         = 1'b1;
      if (!sensor_ok) begin
        event_res = EV_FAULT;
        if (cur.heater) begin
          nxt.heater = 1'b0;
          nxt.mode   = MODE_IDLE;
        end
      end else if (cur.mode == MODE_IDLE) begin
        if (temperature < cfg.minimum_t) begin
          event_res = EV_TOO_COLD;
        end else if (humidity >= cfg.hum_enter) begin
          nxt.mode        = MODE_HEATING;
          nxt.phase_start = now_ms;
          nxt.heater      = 1'b1;
          event_res       = EV_START;
        end
      end else if (temperature >= cfg.cutoff_t) begin
        nxt.heater = 1'b0;
        nxt.mode   = MODE_IDLE;
        event_res  = EV_CUTOFF;
      end else if (humidity < cfg.hum_leave) begin
        nxt.heater = 1'b0;
        nxt.mode   = MODE_IDLE;
        event_res  = EV_HUMID_EXIT;
      end else if (cur.mode == MODE_HEATING) begin
        if (in_phase >= {8'd0, cfg.on_phase}) begin
          nxt.heater      = 1'b0;
          nxt.mode        = MODE_COOLDOWN;
          nxt.phase_start = now_ms;
          event_res       = EV_COOLDOWN;
        end
      end else if (cur.mode == MODE_COOLDOWN) begin
        if (in_phase >= {8'd0, cfg.off_phase}) begin
          if (humidity >= cfg.hum_enter && temperature < cfg.target_t) begin
            nxt.mode        = MODE_HEATING;
            nxt.phase_start = now_ms;
            nxt.heater      = 1'b1;
            event_res       = EV_REHEAT;
          end else begin
            nxt.mode  = MODE_IDLE;
            event_res = EV_DONE;
          end
        end
      end
    end
  end

endmodule
